FILE: hdl/csev_pkg.sv
// ---------------------------------------------------------------------------
// csev_pkg: shared types for the cubic spline evaluator
// Request and result beats, the table write bundle and register addresses.
// ---------------------------------------------------------------------------
`default_nettype none

package csev_pkg;

	typedef enum logic [0:0] {
		REQ_WRITE = 1'b0,
		REQ_EVAL  = 1'b1
	} req_kind_t;

	typedef enum logic [1:0] {
		REG_KNOT_COUNT = 2'd0,
		REG_FLAT_MODE  = 2'd1,
		REG_FLAT_VALUE = 2'd2,
		REG_NONE       = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic               req_type;
		logic        [5:0]  knot_index;
		logic signed [31:0] knot_x;
		logic signed [31:0] coef_cubic;
		logic signed [31:0] coef_square;
		logic signed [31:0] coef_linear;
		logic signed [31:0] coef_const;
		logic signed [31:0] point;
	} req_t;

	typedef struct packed {
		logic signed [31:0] value;
		logic        [5:0]  segment;
		logic               saturated;
	} res_t;

	// One table entry: knot abscissa and the four segment coefficients.
	typedef struct packed {
		logic signed [31:0] knot;
		logic signed [31:0] cubic;
		logic signed [31:0] square;
		logic signed [31:0] linear;
		logic signed [31:0] cnst;
	} entry_t;

	typedef struct packed {
		logic       valid;
		logic [5:0] index;
		entry_t     entry;
	} tbl_wr_t;

endpackage

`default_nettype wire

FILE: hdl/csev_ram.sv
// ---------------------------------------------------------------------------
// csev_ram: generic single-write, single-read RAM
// One write port and one read port with a registered read.
// ---------------------------------------------------------------------------
`default_nettype none

module csev_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  wire                      clk,
	input  wire                      we,
	input  wire  [$clog2(DEPTH)-1:0] waddr,
	input  wire  [WIDTH-1:0]         wdata,
	input  wire                      re,
	input  wire  [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

FILE: hdl/csev_search.sv
// ---------------------------------------------------------------------------
// csev_search: segment search over the knot cells
// Every knot cell but the first has its own comparator; a two-level registered
// count tree turns the compare bits into the segment index.
// ---------------------------------------------------------------------------
`default_nettype none

module csev_search #(
	parameter int MAX_KNOTS = 64
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire  csev_pkg::tbl_wr_t      wr,
	input  wire  signed [31:0]           point,
	input  wire         [6:0]            knot_count,
	output logic [$clog2(MAX_KNOTS)-1:0] seg_s3
);

	localparam int IDX_W  = $clog2(MAX_KNOTS);
	localparam int GROUPS = (MAX_KNOTS + 7) / 8;

	logic signed [31:0]  knot_q [MAX_KNOTS];
	logic [GROUPS*8-1:0] cmp_s1;
	logic [3:0]          grp_s2 [GROUPS];
	logic [IDX_W:0]      n_eff;
	logic [GROUPS*8-1:0] cmp_d;
	logic [IDX_W:0]      total;

	// Knot cells are written as the write beat is accepted.
	always_ff @(posedge clk) begin
		if (wr.valid && (int'(wr.index) < MAX_KNOTS)) begin
			knot_q[wr.index[IDX_W-1:0]] <= wr.entry.knot;
		end
	end

	always_comb begin
		if (knot_count < 7'd2) begin
			n_eff = (IDX_W+1)'(2);
		end else if (int'(knot_count) > MAX_KNOTS) begin
			n_eff = (IDX_W+1)'(MAX_KNOTS);
		end else begin
			n_eff = (IDX_W+1)'(knot_count);
		end
		cmp_d = '0;
		for (int k = 1; k < MAX_KNOTS; k++) begin
			cmp_d[k] = ((IDX_W+1)'(k + 1) < n_eff) && (knot_q[k] < point);
		end
	end

	always_comb begin
		total = '0;
		for (int g = 0; g < GROUPS; g++) begin
			total = total + (IDX_W+1)'(grp_s2[g]);
		end
	end

	always_ff @(posedge clk) begin
		cmp_s1 <= cmp_d;
		for (int g = 0; g < GROUPS; g++) begin
			grp_s2[g] <= 4'($countones(cmp_s1[g*8 +: 8]));
		end
		seg_s3 <= total[IDX_W-1:0];
	end

	// The reset is only used by the checkers below.
	assert property (@(posedge clk) disable iff (!arst_n)
		(knot_count <= 7'd2) |=> (cmp_s1 == '0))
		else $error("knot cell outside the active range was counted");

	assert property (@(posedge clk) disable iff (!arst_n)
		int'(seg_s3) <= MAX_KNOTS - 2)
		else $error("segment beyond last segment");

	assert property (@(posedge clk) disable iff (!arst_n)
		$countones(cmp_s1) <= MAX_KNOTS - 2)
		else $error("more compare hits than interior knots");

endmodule

`default_nettype wire

FILE: hdl/csev_horner.sv
// ---------------------------------------------------------------------------
// csev_horner: one Horner step
// Stage a multiplies acc by dx; stage b rounds, adds the coefficient and
// clamps to 32 bits, flagging any clamp.
// ---------------------------------------------------------------------------
`default_nettype none

module csev_horner #(
	parameter int FRAC_BITS = 16
) (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                in_valid,
	input  wire  signed [31:0] acc,
	input  wire  signed [32:0] dx,
	input  wire  signed [31:0] coef,
	input  wire                sat_in,
	output logic               out_valid,
	output logic signed [31:0] acc_out,
	output logic signed [32:0] dx_out,
	output logic               sat_out
);

	localparam logic signed [65:0] MAX_V = 66'sd2147483647;
	localparam logic signed [65:0] MIN_V = -66'sd2147483648;
	localparam logic signed [65:0] HALF  = 66'sd1 <<< (FRAC_BITS - 1);

	logic               valid_sa;
	logic signed [64:0] prod_sa;
	logic signed [32:0] dx_sa;
	logic signed [31:0] coef_sa;
	logic               sat_sa;
	logic signed [65:0] rnd;
	logic signed [65:0] sum;

	always_comb begin
		rnd = (66'(prod_sa) + HALF) >>> FRAC_BITS;
		sum = rnd + 66'(coef_sa);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_sa  <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			valid_sa  <= in_valid;
			out_valid <= valid_sa;
		end
	end

	always_ff @(posedge clk) begin
		prod_sa <= acc * dx;
		dx_sa   <= dx;
		coef_sa <= coef;
		sat_sa  <= sat_in;
		dx_out  <= dx_sa;
		if (sum > MAX_V) begin
			acc_out <= 32'sh7FFFFFFF;
			sat_out <= 1'b1;
		end else if (sum < MIN_V) begin
			acc_out <= 32'sh80000000;
			sat_out <= 1'b1;
		end else begin
			acc_out <= sum[31:0];
			sat_out <= sat_sa;
		end
	end

endmodule

`default_nettype wire

FILE: hdl/cubic_spline_evaluator_unit.sv
// ---------------------------------------------------------------------------
// cubic_spline_evaluator_unit: piecewise cubic spline evaluator, Q16.16
// Loads knots and segment coefficients, then evaluates points through a
// pipelined segment search and a three-step Horner chain.
// ---------------------------------------------------------------------------
//  channel   signals                         beat moves on
//  request   start, busy, req                start high, busy low
//  result    res_strobe, res                 res_strobe high (one cycle)
//  config    psel, penable, pwrite, paddr,   psel, penable, pwrite, pready
//            pwdata, prdata, pready
//
// One request beat is taken every cycle; busy never rises. An evaluate beat
// passes the search tree (3 stages), the table RAM read (1), the dx subtract
// (1) and three Horner steps of a multiply stage and a round/clamp stage each.
// Write beats give no result. Reset clears the valid bits, the flat mode and
// the flat value and sets the knot count to 2; the tables are not cleared.
// The receiver cannot stall, so nothing in the pipeline ever waits.
// ---------------------------------------------------------------------------
`default_nettype none

module cubic_spline_evaluator_unit #(
	parameter int MAX_KNOTS = 64,
	parameter int FRAC_BITS = 16
) (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                start,
	output logic               busy,
	input  wire csev_pkg::req_t req,
	output logic               res_strobe,
	output csev_pkg::res_t     res,
	input  wire                psel,
	input  wire                penable,
	input  wire                pwrite,
	input  wire  [3:0]         paddr,
	input  wire  [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);

	localparam int IDX_W = $clog2(MAX_KNOTS);

	// Side data that rides beside the Horner chain.
	typedef struct packed {
		logic [IDX_W-1:0]   seg;
		logic               flat;
		logic signed [31:0] linear;
		logic signed [31:0] cnst;
	} side_t;

	logic [6:0]         knot_count_q;
	logic               flat_mode_q;
	logic signed [31:0] flat_value_q;

	logic               accept;
	logic               acc_eval;
	csev_pkg::tbl_wr_t  wr_in;
	csev_pkg::tbl_wr_t  wr_s1, wr_s2, wr_s3;
	logic               valid_s1, valid_s2, valid_s3, valid_s4, valid_s5;
	logic               flat_s1, flat_s2, flat_s3, flat_s4;
	logic signed [31:0] point_s1, point_s2, point_s3, point_s4;
	logic [IDX_W-1:0]   seg_s3, seg_s4;
	csev_pkg::entry_t   rd_s4;
	logic signed [32:0] dx_s5;
	logic signed [31:0] cubic_s5, square_s5;
	side_t              side_s5, side_s6, side_s7, side_s8, side_s9, side_s10, side_s11;
	logic               valid_s7, valid_s9, valid_s11;
	logic signed [31:0] acc_s7, acc_s9, acc_s11;
	logic signed [32:0] dx_s7, dx_s9, dx_s11;
	logic               sat_s7, sat_s9, sat_s11;
	logic [31:0]        seg_wide;
	logic               cfg_wr;
	csev_pkg::reg_idx_t cfg_idx;

	assign busy   = 1'b0;
	assign pready = 1'b1;
	assign accept   = start && !busy;
	assign acc_eval = accept && (req.req_type == csev_pkg::REQ_EVAL);

	// Configuration port. Registers sit at byte addresses 0, 4 and 8.
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign cfg_idx = csev_pkg::reg_idx_t'(paddr[3:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			knot_count_q <= 7'd2;
			flat_mode_q  <= 1'b0;
			flat_value_q <= '0;
		end else if (cfg_wr) begin
			unique case (cfg_idx)
				csev_pkg::REG_KNOT_COUNT: knot_count_q <= pwdata[6:0];
				csev_pkg::REG_FLAT_MODE:  flat_mode_q  <= pwdata[0];
				csev_pkg::REG_FLAT_VALUE: flat_value_q <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (cfg_idx)
			csev_pkg::REG_KNOT_COUNT: prdata = {25'd0, knot_count_q};
			csev_pkg::REG_FLAT_MODE:  prdata = {31'd0, flat_mode_q};
			csev_pkg::REG_FLAT_VALUE: prdata = flat_value_q;
			default:                  prdata = '0;
		endcase
	end

	// A write beat becomes a table write bundle. The knot cells take it at
	// once; the RAM takes it from wr_s3, after wr_s1 and wr_s2, at the stage where
	// evaluate beats read, so reads and writes reach the RAM in beat order.
	always_comb begin
		wr_in.valid        = accept && (req.req_type == csev_pkg::REQ_WRITE);
		wr_in.index        = req.knot_index;
		wr_in.entry.knot   = req.knot_x;
		wr_in.entry.cubic  = req.coef_cubic;
		wr_in.entry.square = req.coef_square;
		wr_in.entry.linear = req.coef_linear;
		wr_in.entry.cnst   = req.coef_const;
	end

	csev_search #(.MAX_KNOTS(MAX_KNOTS)) u_search (
		.clk        (clk),
		.arst_n     (arst_n),
		.wr         (wr_in),
		.point      (req.point),
		.knot_count (knot_count_q),
		.seg_s3     (seg_s3)
	);

	csev_ram #(.WIDTH($bits(csev_pkg::entry_t)), .DEPTH(MAX_KNOTS)) u_table (
		.clk   (clk),
		.we    (wr_s3.valid && (int'(wr_s3.index) < MAX_KNOTS)),
		.waddr (wr_s3.index[IDX_W-1:0]),
		.wdata (wr_s3.entry),
		.re    (valid_s3),
		.raddr (seg_s3),
		.rdata (rd_s4)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			wr_s1    <= '0;
			wr_s2    <= '0;
			wr_s3    <= '0;
		end else begin
			valid_s1 <= acc_eval;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
			wr_s1    <= wr_in;
			wr_s2    <= wr_s1;
			wr_s3    <= wr_s2;
		end
	end

	always_ff @(posedge clk) begin
		point_s1    <= req.point;
		point_s2    <= point_s1;
		point_s3    <= point_s2;
		point_s4    <= point_s3;
		flat_s1     <= flat_mode_q;
		flat_s2     <= flat_s1;
		flat_s3     <= flat_s2;
		flat_s4     <= flat_s3;
		seg_s4      <= seg_s3;
		// dx is exact in 33 bits.
		dx_s5          <= 33'(point_s4) - 33'(rd_s4.knot);
		cubic_s5       <= rd_s4.cubic;
		square_s5      <= rd_s4.square;
		side_s5.seg    <= seg_s4;
		side_s5.flat   <= flat_s4;
		side_s5.linear <= rd_s4.linear;
		side_s5.cnst   <= rd_s4.cnst;
		side_s6        <= side_s5;
		side_s7        <= side_s6;
		side_s8        <= side_s7;
		side_s9        <= side_s8;
		side_s10       <= side_s9;
		side_s11       <= side_s10;
	end

	csev_horner #(.FRAC_BITS(FRAC_BITS)) u_step_sq (
		.clk(clk), .arst_n(arst_n), .in_valid(valid_s5), .acc(cubic_s5), .dx(dx_s5),
		.coef(square_s5), .sat_in(1'b0), .out_valid(valid_s7), .acc_out(acc_s7),
		.dx_out(dx_s7), .sat_out(sat_s7)
	);

	csev_horner #(.FRAC_BITS(FRAC_BITS)) u_step_lin (
		.clk(clk), .arst_n(arst_n), .in_valid(valid_s7), .acc(acc_s7), .dx(dx_s7),
		.coef(side_s7.linear), .sat_in(sat_s7), .out_valid(valid_s9), .acc_out(acc_s9),
		.dx_out(dx_s9), .sat_out(sat_s9)
	);

	csev_horner #(.FRAC_BITS(FRAC_BITS)) u_step_cst (
		.clk(clk), .arst_n(arst_n), .in_valid(valid_s9), .acc(acc_s9), .dx(dx_s9),
		.coef(side_s9.cnst), .sat_in(sat_s9), .out_valid(valid_s11), .acc_out(acc_s11),
		.dx_out(dx_s11), .sat_out(sat_s11)
	);

	// Flat mode gives the configured constant, segment 0 and no saturation.
	assign seg_wide   = 32'(side_s11.seg);
	assign res_strobe = valid_s11;
	always_comb begin
		if (side_s11.flat) begin
			res.value     = flat_value_q;
			res.segment   = '0;
			res.saturated = 1'b0;
		end else begin
			res.value     = acc_s11;
			res.segment   = seg_wide[5:0];
			res.saturated = sat_s11;
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		res_strobe |-> $past(acc_eval, 11))
		else $error("result beat without a matching evaluate beat");

	assert property (@(posedge clk) disable iff (!arst_n)
		!(wr_s3.valid && valid_s3))
		else $error("table read and write in the same cycle");

	assert property (@(posedge clk) disable iff (!arst_n)
		(res_strobe && side_s11.flat) |-> (res.segment == '0 && !res.saturated))
		else $error("flat result carries segment or saturation");

	assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s11 && (dx_s11 == 33'sd0) && !side_s11.flat) |-> (acc_s11 == side_s11.cnst))
		else $error("zero offset must return the constant term");

endmodule

`default_nettype wire
